>>> rtl/mee_pkg.sv
// ----------------------------------------------------------------------------
// mee_pkg
// Shared widths, codes, control structs and helpers for the ellipse outline
// point generator.
// ----------------------------------------------------------------------------
package mee_pkg;

  localparam int MAX_RADIUS = 4095;
  localparam int COORD_BITS = 16;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 17;
  localparam int RAD_W  = 12;
  localparam int X_W    = 13;
  localparam int Y_W    = 14;
  localparam int SQ_W   = 24;
  localparam int T_W    = SQ_W + RAD_W;
  localparam int SL_W   = 38;
  localparam int DEC_W  = 53;
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 55;
  localparam int TXSQ_W = 27;
  localparam int YMSQ_W = 25;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_RXRY,
    ST_SEED,
    ST_SEED_DIV,
    ST_DEC,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_T6,
    ST_T_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_RX_RX,
    MS_RY_RY,
    MS_RX2_RY,
    MS_TX_TX,
    MS_YM_YM,
    MS_RY2_TXSQ,
    MS_RX2_YMSQ,
    MS_RX2_RY2
  } msel_e;

  typedef struct packed {
    logic  ready;
    logic  accept;
    msel_e msel;
    logic  ld_rx2;
    logic  ld_ry2;
    logic  seed;
    logic  seed_div;
    logic  ld_txsq;
    logic  ld_ymsq;
    logic  acc_first;
    logic  acc_add;
    logic  acc_sub;
    logic  settle_div;
    logic  dec_step;
    logic  go_settle;
    logic  write_out;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic op_next;
    logic bad;
    logic active;
    logic degen;
    logic need_settle;
    logic pend;
    logic out_free;
  } stat_t;

  // signed divide by four, rounding toward zero
  function automatic logic signed [DEC_W-1:0] div4(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v[ACC_W-1] ? v + ACC_W'(3) : v;
    return DEC_W'(t >>> 2);
  endfunction

endpackage

>>> rtl/mee_mul.sv
// ----------------------------------------------------------------------------
// mee_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mee_mul (
  input  logic                        clk_i,
  input  logic [mee_pkg::MUL_W-1:0]   a_i,
  input  logic [mee_pkg::MUL_W-1:0]   b_i,
  output logic [mee_pkg::PROD_W-1:0]  p_o
);
  import mee_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/mee_seq.sv
// ----------------------------------------------------------------------------
// mee_seq
// Sequencer: start set-up, point steps, region-two seeding and output hand-off.
// ----------------------------------------------------------------------------
module mee_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mee_pkg::stat_t  stat_i,
  output mee_pkg::ctl_t   ctl_o
);
  import mee_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          if (!stat_i.op_next) begin
            state_d = stat_i.bad ? ST_EMIT : ST_SQX;
          end else begin
            state_d = (stat_i.active && !stat_i.degen) ? ST_DEC : ST_EMIT;
          end
        end
      end
      ST_SQX:      state_d = ST_SQY;
      ST_SQY:      state_d = ST_RXRY;
      ST_RXRY:     state_d = ST_SEED;
      ST_SEED:     state_d = ST_SEED_DIV;
      ST_SEED_DIV: state_d = stat_i.need_settle ? ST_T1 : ST_IDLE;
      ST_DEC: begin
        if (stat_i.need_settle) begin
          state_d = ST_T1;
        end else begin
          state_d = stat_i.out_free ? ST_IDLE : ST_EMIT;
        end
      end
      ST_T1:       state_d = ST_T2;
      ST_T2:       state_d = ST_T3;
      ST_T3:       state_d = ST_T4;
      ST_T4:       state_d = ST_T5;
      ST_T5:       state_d = ST_T6;
      ST_T6:       state_d = ST_T_DIV;
      ST_T_DIV: begin
        if (stat_i.pend && !stat_i.out_free) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT:     state_d = stat_i.out_free ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    ctl_o.msel = MS_NONE;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.ready  = 1'b1;
        ctl_o.accept = stat_i.in_valid;
      end
      ST_SQX: ctl_o.msel = MS_RX_RX;
      ST_SQY: begin
        ctl_o.ld_rx2 = 1'b1;
        ctl_o.msel   = MS_RY_RY;
      end
      ST_RXRY: begin
        ctl_o.ld_ry2 = 1'b1;
        ctl_o.msel   = MS_RX2_RY;
      end
      ST_SEED: ctl_o.seed = 1'b1;
      ST_SEED_DIV: begin
        ctl_o.seed_div  = 1'b1;
        ctl_o.go_settle = stat_i.need_settle;
      end
      ST_DEC: begin
        ctl_o.dec_step  = 1'b1;
        ctl_o.go_settle = stat_i.need_settle;
        ctl_o.write_out = !stat_i.need_settle && stat_i.out_free;
      end
      ST_T1: ctl_o.msel = MS_TX_TX;
      ST_T2: begin
        ctl_o.ld_txsq = 1'b1;
        ctl_o.msel    = MS_YM_YM;
      end
      ST_T3: begin
        ctl_o.ld_ymsq = 1'b1;
        ctl_o.msel    = MS_RY2_TXSQ;
      end
      ST_T4: begin
        ctl_o.acc_first = 1'b1;
        ctl_o.msel      = MS_RX2_YMSQ;
      end
      ST_T5: begin
        ctl_o.acc_add = 1'b1;
        ctl_o.msel    = MS_RX2_RY2;
      end
      ST_T6: ctl_o.acc_sub = 1'b1;
      ST_T_DIV: begin
        ctl_o.settle_div = 1'b1;
        ctl_o.write_out  = stat_i.pend && stat_i.out_free;
      end
      ST_EMIT: ctl_o.write_out = stat_i.out_free;
      default: ctl_o.ready = 1'b0;
    endcase
  end

endmodule

>>> rtl/midpoint_ellipse_outline.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_outline
// Midpoint ellipse outline generator: one group of four symmetric points per
// next word, built on a shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes a start word (op 0: centre and
// radii) or a next word (op 1). Output channel (out_valid_o/out_ready_i)
// carries one result word per next word and per rejected start; an accepted
// start returns nothing.
// Sequencing: in_ready_o is high only while the sequencer is idle.
//   next word in either region: result registered from the decision state.
//   start word: three chained squarings/products on the multiplier, then the seed.
//   entry to region two (after a step, or at start with one radius zero):
//   a six-step seed of the second decision variable, then its divide by four.
//   rejected start, idle next, degenerate next: result from the hand-off state.
// The output register decouples the sides: a new word is taken while a result
// waits; the block holds in its hand-off state only if a second result is due
// before the first has been taken.
// Reset: asynchronous, active low; block idle, no ellipse active, output
// channel empty.
// ----------------------------------------------------------------------------
module midpoint_ellipse_outline #(
  parameter int COORD_BITS = mee_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic signed [mee_pkg::IN_W-1:0]   center_x_i,
  input  logic signed [mee_pkg::IN_W-1:0]   center_y_i,
  input  logic signed [mee_pkg::IN_W-1:0]   radius_x_i,
  input  logic signed [mee_pkg::IN_W-1:0]   radius_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              valid_res_o,
  output logic                              error_o,
  output logic                              single_point_o,
  output logic                              last_o,
  output logic signed [mee_pkg::OUT_W-1:0]  x_right_o,
  output logic signed [mee_pkg::OUT_W-1:0]  x_left_o,
  output logic signed [mee_pkg::OUT_W-1:0]  y_lower_o,
  output logic signed [mee_pkg::OUT_W-1:0]  y_upper_o
);
  import mee_pkg::*;

  localparam logic signed [IN_W-1:0] MaxRad = IN_W'(MAX_RADIUS);

  ctl_t  ctl;
  stat_t stat;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  // ellipse state
  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [RAD_W-1:0]             rx_q, rx_d, ry_q, ry_d;
  logic [SQ_W-1:0]              rx2_q, rx2_d, ry2_q, ry2_d;
  logic [X_W-1:0]               x_q, x_d;
  logic signed [Y_W-1:0]        y_q, y_d;
  logic signed [SL_W-1:0]       px_q, px_d, py_q, py_d;
  logic signed [DEC_W-1:0]      dec_q, dec_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic [TXSQ_W-1:0]            txsq_q, txsq_d;
  logic [YMSQ_W-1:0]            ymsq_q, ymsq_d;
  logic                         xinc_q, xinc_d, ydec_q, ydec_d;
  logic                         r2_q, r2_d, active_q, active_d, degen_q, degen_d;

  // pending result word
  logic                    pend_q, pend_d, pstep_q, pstep_d;
  logic                    pvalid_q, pvalid_d, perr_q, perr_d;
  logic                    psingle_q, psingle_d, plast_q, plast_d;
  logic signed [OUT_W-1:0] pxr_q, pxr_d, pxl_q, pxl_d, pyl_q, pyl_d, pyu_q, pyu_d;

  // output register
  logic                    ovalid_q, ovalid_d, ores_q, ores_d, oerr_q, oerr_d;
  logic                    osingle_q, osingle_d, olast_q, olast_d;
  logic signed [OUT_W-1:0] oxr_q, oxr_d, oxl_q, oxl_d, oyl_q, oyl_d, oyu_q, oyu_d;

  logic                    bad, step_last, dec_neg, dec_pos, xi, yd;
  logic [T_W-1:0]          t_prod;
  logic [X_W:0]            tx;
  logic signed [Y_W:0]     ym;
  logic [Y_W-1:0]          ym_abs;
  logic signed [OUT_W-1:0] cx_ext, cy_ext, xo_ext, yo_ext;
  logic signed [SL_W-1:0]  two_rx2, two_ry2;

  mee_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  mee_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign bad = (radius_x_i < 0) || (radius_y_i < 0) ||
               (radius_x_i > MaxRad) || (radius_y_i > MaxRad);

  assign tx     = {x_q, 1'b1};
  assign ym     = $signed({y_q[Y_W-1], y_q}) - $signed((Y_W+1)'(1));
  assign ym_abs = Y_W'(ym[Y_W] ? -ym : ym);
  assign t_prod = prod[T_W-1:0];
  assign two_rx2 = SL_W'({rx2_q, 1'b0});
  assign two_ry2 = SL_W'({ry2_q, 1'b0});

  assign cx_ext = {{(OUT_W-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q};
  assign cy_ext = {{(OUT_W-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q};
  assign xo_ext = OUT_W'(x_q);
  assign yo_ext = {{(OUT_W-Y_W){y_q[Y_W-1]}}, y_q};

  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_q != '0);
  assign xi      = !r2_q || !dec_pos;
  assign yd      = r2_q || !dec_neg;

  assign step_last = pstep_q && r2_q && y_q[Y_W-1];

  always_comb begin
    stat.in_valid    = in_valid_i;
    stat.op_next     = (op_i == OP_NEXT);
    stat.bad         = bad;
    stat.active      = active_q;
    stat.degen       = degen_q;
    stat.need_settle = !r2_q && !(px_q < py_q) && !degen_q;
    stat.pend        = pend_q;
    stat.out_free    = !ovalid_q || out_ready_i;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.msel)
      MS_RX_RX: begin
        mul_a = MUL_W'(rx_q);
        mul_b = MUL_W'(rx_q);
      end
      MS_RY_RY: begin
        mul_a = MUL_W'(ry_q);
        mul_b = MUL_W'(ry_q);
      end
      MS_RX2_RY: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(ry_q);
      end
      MS_TX_TX: begin
        mul_a = MUL_W'(tx);
        mul_b = MUL_W'(tx);
      end
      MS_YM_YM: begin
        mul_a = MUL_W'(ym_abs);
        mul_b = MUL_W'(ym_abs);
      end
      MS_RY2_TXSQ: begin
        mul_a = MUL_W'(ry2_q);
        mul_b = MUL_W'(txsq_q);
      end
      MS_RX2_YMSQ: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(ymsq_q);
      end
      MS_RX2_RY2: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cx_d = cx_q; cy_d = cy_q; rx_d = rx_q; ry_d = ry_q;
    rx2_d = rx2_q; ry2_d = ry2_q; x_d = x_q; y_d = y_q;
    px_d = px_q; py_d = py_q; dec_d = dec_q; acc_d = acc_q;
    txsq_d = txsq_q; ymsq_d = ymsq_q; xinc_d = xinc_q; ydec_d = ydec_q;
    r2_d = r2_q; active_d = active_q; degen_d = degen_q;
    pend_d = pend_q; pstep_d = pstep_q; pvalid_d = pvalid_q; perr_d = perr_q;
    psingle_d = psingle_q; plast_d = plast_q;
    pxr_d = pxr_q; pxl_d = pxl_q; pyl_d = pyl_q; pyu_d = pyu_q;
    ovalid_d = ovalid_q; ores_d = ores_q; oerr_d = oerr_q;
    osingle_d = osingle_q; olast_d = olast_q;
    oxr_d = oxr_q; oxl_d = oxl_q; oyl_d = oyl_q; oyu_d = oyu_q;

    if (ctl.accept) begin
      pstep_d   = 1'b0;
      pvalid_d  = 1'b0;
      perr_d    = 1'b0;
      psingle_d = 1'b0;
      plast_d   = 1'b0;
      pxr_d     = '0;
      pxl_d     = '0;
      pyl_d     = '0;
      pyu_d     = '0;
      if (op_i == OP_START) begin
        if (bad) begin
          pend_d   = 1'b1;
          perr_d   = 1'b1;
          plast_d  = 1'b1;
          active_d = 1'b0;
        end else begin
          pend_d = 1'b0;
          cx_d   = center_x_i[COORD_BITS-1:0];
          cy_d   = center_y_i[COORD_BITS-1:0];
          rx_d   = radius_x_i[RAD_W-1:0];
          ry_d   = radius_y_i[RAD_W-1:0];
        end
      end else begin
        pend_d = 1'b1;
        if (active_q) begin
          pvalid_d = 1'b1;
          pxr_d    = cx_ext + xo_ext;
          pxl_d    = cx_ext - xo_ext;
          pyl_d    = cy_ext + yo_ext;
          pyu_d    = cy_ext - yo_ext;
          if (degen_q) begin
            psingle_d = 1'b1;
            plast_d   = 1'b1;
            active_d  = 1'b0;
          end else begin
            pstep_d = 1'b1;
            xinc_d  = xi;
            ydec_d  = yd;
            if (xi) begin
              x_d  = x_q + 1'b1;
              px_d = px_q + two_ry2;
            end
            if (yd) begin
              y_d  = y_q - Y_W'(1);
              py_d = py_q - two_rx2;
            end
          end
        end
      end
    end

    if (ctl.ld_rx2) rx2_d = prod[SQ_W-1:0];
    if (ctl.ld_ry2) ry2_d = prod[SQ_W-1:0];

    if (ctl.seed) begin
      py_d    = SL_W'({t_prod, 1'b0});
      px_d    = '0;
      x_d     = '0;
      y_d     = Y_W'(ry_q);
      acc_d   = ACC_W'({ry2_q, 2'b00}) - ACC_W'({t_prod, 2'b00}) + ACC_W'(rx2_q);
      r2_d    = 1'b0;
      degen_d = (rx_q == '0) && (ry_q == '0);
      active_d = 1'b1;
    end

    if (ctl.seed_div || ctl.settle_div) dec_d = div4(acc_q);

    if (ctl.dec_step) begin
      dec_d = dec_q + DEC_W'(r2_q ? rx2_q : ry2_q)
            + (xinc_q ? DEC_W'(px_q) : '0)
            - (ydec_q ? DEC_W'(py_q) : '0);
    end

    if (ctl.go_settle) r2_d = 1'b1;

    if (ctl.ld_txsq)   txsq_d = prod[TXSQ_W-1:0];
    if (ctl.ld_ymsq)   ymsq_d = prod[YMSQ_W-1:0];
    if (ctl.acc_first) acc_d  = ACC_W'(prod);
    if (ctl.acc_add)   acc_d  = acc_q + ACC_W'({prod, 2'b00});
    if (ctl.acc_sub)   acc_d  = acc_q - ACC_W'({prod, 2'b00});

    if (ctl.write_out) begin
      ovalid_d  = 1'b1;
      ores_d    = pvalid_q;
      oerr_d    = perr_q;
      osingle_d = psingle_q;
      olast_d   = plast_q || step_last;
      oxr_d     = pxr_q;
      oxl_d     = pxl_q;
      oyl_d     = pyl_q;
      oyu_d     = pyu_q;
      pend_d    = 1'b0;
      if (step_last) active_d = 1'b0;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q     <= 1'b0;
      active_q <= 1'b0;
      degen_q  <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      r2_q     <= r2_d;
      active_q <= active_d;
      degen_q  <= degen_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; rx_q <= rx_d; ry_q <= ry_d;
    rx2_q <= rx2_d; ry2_q <= ry2_d; x_q <= x_d; y_q <= y_d;
    px_q <= px_d; py_q <= py_d; dec_q <= dec_d; acc_q <= acc_d;
    txsq_q <= txsq_d; ymsq_q <= ymsq_d; xinc_q <= xinc_d; ydec_q <= ydec_d;
    pstep_q <= pstep_d; pvalid_q <= pvalid_d; perr_q <= perr_d;
    psingle_q <= psingle_d; plast_q <= plast_d;
    pxr_q <= pxr_d; pxl_q <= pxl_d; pyl_q <= pyl_d; pyu_q <= pyu_d;
    ores_q <= ores_d; oerr_q <= oerr_d; osingle_q <= osingle_d; olast_q <= olast_d;
    oxr_q <= oxr_d; oxl_q <= oxl_d; oyl_q <= oyl_d; oyu_q <= oyu_d;
  end

  assign in_ready_o     = ctl.ready;
  assign out_valid_o    = ovalid_q;
  assign valid_res_o    = ores_q;
  assign error_o        = oerr_q;
  assign single_point_o = osingle_q;
  assign last_o         = olast_q;
  assign x_right_o      = oxr_q;
  assign x_left_o       = oxl_q;
  assign y_lower_o      = oyl_q;
  assign y_upper_o      = oyu_q;

endmodule
